FILE: sv/bps_pkg.sv
// Package for the buzzer pattern sequencer: field widths, mode codes,
// pattern and tone constants, and the control/status structs.
// No dependencies.
package bps_pkg;

   localparam int FREQ_W    = 16;
   localparam int MODE_W    = 4;
   localparam int TICK_W    = 9;
   localparam int PERIOD_W  = 12;
   localparam int HALF_W    = 11;
   localparam int DIVISOR_W = 11;
   localparam int QUOT_W    = 10;
   localparam int STEP_W    = 4;

   typedef enum logic [MODE_W-1:0] {
      MODE_STOP     = 4'd0,
      MODE_CLICK    = 4'd1,
      MODE_MID      = 4'd2,
      MODE_EXIT     = 4'd3,
      MODE_CALDONE  = 4'd4,
      MODE_BIND     = 4'd5,
      MODE_STATIC   = 4'd6,
      MODE_RFLOST   = 4'd7,
      MODE_THROTTLE = 4'd8,
      MODE_FAST     = 4'd9
   } mode_type;

   localparam logic [19:0] DIVIDEND = 20'd1000000;
   localparam logic [DIVISOR_W-1:0] DIV_HEAD = DIVISOR_W'(DIVIDEND[19:QUOT_W]);
   localparam logic [QUOT_W-1:0] DIV_TAIL = DIVIDEND[QUOT_W-1:0];
   localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(QUOT_W - 1);

   localparam logic [FREQ_W-1:0] FREQ_MIN = 16'd1000;
   localparam logic [FREQ_W-1:0] FREQ_MAX = 16'd2000;

   localparam logic [PERIOD_W-1:0] RESET_PERIOD = 12'd1000;
   localparam logic [HALF_W-1:0]   RESET_HALF   = 11'd500;

   localparam logic [PERIOD_W-1:0] P512 = 12'd1953;
   localparam logic [HALF_W-1:0]   H512 = 11'd976;
   localparam logic [PERIOD_W-1:0] P413 = 12'd2421;
   localparam logic [HALF_W-1:0]   H413 = 11'd1210;
   localparam logic [PERIOD_W-1:0] P610 = 12'd1639;
   localparam logic [HALF_W-1:0]   H610 = 11'd819;

   localparam logic [TICK_W-1:0] CLICK_LEN = 9'd3;
   localparam logic [TICK_W-1:0] MID_LEN   = 9'd20;
   localparam logic [TICK_W-1:0] EXIT_LEN  = 9'd15;
   localparam logic [TICK_W-1:0] CAL_LEN   = 9'd40;
   localparam logic [TICK_W-1:0] ALARM_LEN = 9'd100;
   localparam logic [TICK_W-1:0] FAST_LEN  = 9'd10;

   typedef struct packed {
      logic div_load;
      logic div_step;
      logic tick_en;
      logic out_load;
   } ctl_cmd_type;

   typedef struct packed {
      logic is_cmd;
      logic cmd_change;
      logic div_last;
   } dp_status_type;

   function automatic logic in_win(input logic [TICK_W-1:0] c,
                                   input logic [TICK_W-1:0] lo,
                                   input logic [TICK_W-1:0] hi);
      return (c >= lo) && (c < hi);
   endfunction

endpackage

FILE: sv/bps_if.sv
// Handshake channels of the buzzer pattern sequencer: request and response.
// Depends on bps_pkg for the field widths.
interface bps_req_if;
   logic                       valid;
   logic                       ready;
   logic                       op;
   logic [bps_pkg::FREQ_W-1:0] tone_freq;
   logic [bps_pkg::MODE_W-1:0] mode_request;

   modport source (output valid, output op, output tone_freq, output mode_request,
                   input ready);
   modport sink (input valid, input op, input tone_freq, input mode_request,
                 output ready);
endinterface

interface bps_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         buzzer_on;
   logic [bps_pkg::PERIOD_W-1:0] tone_period;
   logic [bps_pkg::HALF_W-1:0]   tone_half;
   logic [bps_pkg::MODE_W-1:0]   current_mode;

   modport source (output valid, output buzzer_on, output tone_period,
                   output tone_half, output current_mode, input ready);
   modport sink (input valid, input buzzer_on, input tone_period,
                 input tone_half, input current_mode, output ready);
endinterface

FILE: sv/buzzer_pattern_sequencer_unit.sv
// Buzzer pattern sequencer top level: controller, datapath and channel ports.
// A tick or an ignored command passes from idle to the publish state; a mode
// change first runs the 10-step serial tone divider between them. Publish waits
// while the response register is full and unread, and requests are taken only in idle.
// A new request is taken while the previous response waits in its register.
// Reset (synchronous): stop mode, count 0, output off, period 1000, half 500.
module buzzer_pattern_sequencer_unit #(
   parameter int BIND_CYCLE = 500
) (
   input logic clock,
   input logic reset,
   bps_req_if.sink   req_ch,
   bps_rsp_if.source rsp_ch
);
   import bps_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type status;

   bps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   bps_dp #(
      .BIND_CYCLE (BIND_CYCLE)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_op           (req_ch.op),
      .req_tone_freq    (req_ch.tone_freq),
      .req_mode_request (req_ch.mode_request),
      .rsp_buzzer_on    (rsp_ch.buzzer_on),
      .rsp_tone_period  (rsp_ch.tone_period),
      .rsp_tone_half    (rsp_ch.tone_half),
      .rsp_current_mode (rsp_ch.current_mode)
   );

endmodule

FILE: sv/bps_dp.sv
// Datapath of the buzzer pattern sequencer: mode and tone state, tick
// patterns, a bit-serial tone divider and the response register. Uses bps_pkg.
module bps_dp #(
   parameter int BIND_CYCLE = 500
) (
   input  logic                         clock,
   input  logic                         reset,
   input  bps_pkg::ctl_cmd_type         cmd,
   output bps_pkg::dp_status_type       status,
   input  logic                         req_op,
   input  logic [bps_pkg::FREQ_W-1:0]   req_tone_freq,
   input  logic [bps_pkg::MODE_W-1:0]   req_mode_request,
   output logic                         rsp_buzzer_on,
   output logic [bps_pkg::PERIOD_W-1:0] rsp_tone_period,
   output logic [bps_pkg::HALF_W-1:0]   rsp_tone_half,
   output logic [bps_pkg::MODE_W-1:0]   rsp_current_mode
);
   import bps_pkg::*;

   localparam logic [TICK_W-1:0] BIND_END = TICK_W'(BIND_CYCLE);

   mode_type              mode_ff, mode_in, pend_ff, pend_in;
   logic [TICK_W-1:0]     tick_ff, tick_in, tick_inc;
   logic                  oe_ff, oe_in;
   logic [PERIOD_W-1:0]   period_ff, period_in;
   logic [HALF_W-1:0]     half_ff, half_in;

   logic [DIVISOR_W-1:0]  divisor_ff, divisor_in, rem_ff, rem_in;
   logic [QUOT_W-1:0]     quot_ff, quot_in, tail_ff, tail_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [DIVISOR_W:0]    trial;
   logic                  fits;
   logic [FREQ_W-1:0]     freq_clamped;

   logic                  out_on_ff;
   logic [PERIOD_W-1:0]   out_period_ff;
   logic [HALF_W-1:0]     out_half_ff;
   mode_type              out_mode_ff;

   assign status.is_cmd     = req_op;
   assign status.cmd_change = req_op && (req_mode_request <= MODE_FAST)
                              && (req_mode_request != mode_ff);
   assign status.div_last   = (step_ff == DIV_LAST);

   assign tick_inc = tick_ff + 1'b1;
   assign trial    = {rem_ff, tail_ff[QUOT_W-1]};
   assign fits     = trial >= {1'b0, divisor_ff};

   always_comb begin
      if (req_tone_freq > FREQ_MAX) begin
         freq_clamped = FREQ_MAX;
      end else if (req_tone_freq < FREQ_MIN) begin
         freq_clamped = FREQ_MIN;
      end else begin
         freq_clamped = req_tone_freq;
      end
   end

   always_comb begin
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      quot_in    = quot_ff;
      tail_in    = tail_ff;
      step_in    = step_ff;
      pend_in    = pend_ff;
      if (cmd.div_load) begin
         divisor_in = freq_clamped[DIVISOR_W-1:0];
         rem_in     = DIV_HEAD;
         quot_in    = '0;
         tail_in    = DIV_TAIL;
         step_in    = '0;
         pend_in    = mode_type'(req_mode_request);
      end else if (cmd.div_step) begin
         rem_in  = fits ? DIVISOR_W'(trial - {1'b0, divisor_ff}) : trial[DIVISOR_W-1:0];
         quot_in = {quot_ff[QUOT_W-2:0], fits};
         tail_in = {tail_ff[QUOT_W-2:0], 1'b0};
         step_in = step_ff + 1'b1;
      end
   end

   always_comb begin
      mode_in   = mode_ff;
      tick_in   = tick_ff;
      oe_in     = oe_ff;
      period_in = period_ff;
      half_in   = half_ff;
      if (cmd.div_step && status.div_last) begin
         mode_in   = pend_ff;
         tick_in   = '0;
         oe_in     = 1'b1;
         period_in = PERIOD_W'(quot_in);
         half_in   = HALF_W'(quot_in[QUOT_W-1:1]);
      end else if (cmd.tick_en) begin
         case (mode_ff)
            MODE_STOP: begin
               tick_in = '0;
               oe_in   = 1'b0;
            end
            MODE_CLICK: begin
               if (tick_ff < CLICK_LEN) tick_in = tick_inc;
               else mode_in = MODE_STOP;
            end
            MODE_MID: begin
               if (tick_ff < MID_LEN) tick_in = tick_inc;
               else mode_in = MODE_STOP;
            end
            MODE_EXIT: begin
               if (tick_ff < EXIT_LEN) tick_in = tick_inc;
               else mode_in = MODE_STOP;
               oe_in = (tick_in < 9'd5) || (tick_in > 9'd10);
            end
            MODE_CALDONE: begin
               if (tick_ff < CAL_LEN) tick_in = tick_inc;
               else mode_in = MODE_STOP;
               oe_in = 1'b1;
            end
            MODE_BIND: begin
               if (tick_ff >= BIND_END) begin
                  tick_in = '0;
               end else begin
                  tick_in = tick_inc;
                  if (in_win(tick_inc, 9'd40, 9'd90) || in_win(tick_inc, 9'd100, 9'd150)
                      || in_win(tick_inc, 9'd160, 9'd210)
                      || in_win(tick_inc, 9'd280, 9'd330)
                      || in_win(tick_inc, 9'd400, 9'd500)) begin
                     oe_in = 1'b1; period_in = P512; half_in = H512;
                  end else if (in_win(tick_inc, 9'd220, 9'd255)
                               || in_win(tick_inc, 9'd340, 9'd375)) begin
                     oe_in = 1'b1; period_in = P413; half_in = H413;
                  end else if (in_win(tick_inc, 9'd255, 9'd280)
                               || in_win(tick_inc, 9'd375, 9'd400)) begin
                     oe_in = 1'b1; period_in = P610; half_in = H610;
                  end else begin
                     oe_in = 1'b0;
                  end
               end
            end
            MODE_STATIC, MODE_RFLOST, MODE_THROTTLE: begin
               tick_in = (tick_ff < ALARM_LEN) ? tick_inc : '0;
               oe_in = tick_in < 9'd5;
               if (mode_ff != MODE_STATIC) begin
                  oe_in = oe_in || ((tick_in > 9'd10) && (tick_in < 9'd15))
                          || ((tick_in > 9'd20) && (tick_in < 9'd25));
               end
               if (mode_ff == MODE_THROTTLE) begin
                  oe_in = oe_in || ((tick_in > 9'd30) && (tick_in < 9'd35));
               end
            end
            MODE_FAST: begin
               tick_in = (tick_ff < FAST_LEN) ? tick_inc : '0;
               oe_in   = tick_in < 9'd5;
            end
            default: begin
               tick_in = tick_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_STOP;
         tick_ff   <= '0;
         oe_ff     <= 1'b0;
         period_ff <= RESET_PERIOD;
         half_ff   <= RESET_HALF;
      end else begin
         mode_ff   <= mode_in;
         tick_ff   <= tick_in;
         oe_ff     <= oe_in;
         period_ff <= period_in;
         half_ff   <= half_in;
      end
   end

   always_ff @(posedge clock) begin
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
      quot_ff    <= quot_in;
      tail_ff    <= tail_in;
      step_ff    <= step_in;
      pend_ff    <= pend_in;
      if (cmd.out_load) begin
         out_on_ff     <= oe_ff;
         out_period_ff <= period_ff;
         out_half_ff   <= half_ff;
         out_mode_ff   <= mode_ff;
      end
   end

   assign rsp_buzzer_on    = out_on_ff;
   assign rsp_tone_period  = out_period_ff;
   assign rsp_tone_half    = out_half_ff;
   assign rsp_current_mode = out_mode_ff;

   a_half_tracks_period: assert property (@(posedge clock) disable iff (reset)
      half_ff == HALF_W'(period_ff[PERIOD_W-1:1]))
      else $error("half period out of step with period");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> rem_ff < divisor_ff)
      else $error("divider remainder not below divisor");

   a_commit_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_step && status.div_last) |=>
      (period_ff >= 12'd500) && (period_ff <= 12'd1000) && oe_ff)
      else $error("tone period from divider out of range");

endmodule

FILE: sv/bps_ctrl.sv
// Controller of the buzzer pattern sequencer: sequences request intake,
// the tone divider and the response register. Uses bps_pkg.
module bps_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  bps_pkg::dp_status_type status,
   output bps_pkg::ctl_cmd_type   cmd
);
   import bps_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_PUBLISH
   } state_type;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      req_take;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = out_valid_ff;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (status.cmd_change) begin
                  cmd.div_load = 1'b1;
                  state_in     = ST_DIVIDE;
               end else begin
                  cmd.tick_en = !status.is_cmd;
                  state_in    = ST_PUBLISH;
               end
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = ST_PUBLISH;
         end
         ST_PUBLISH: begin
            if (!out_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      out_valid_in = cmd.out_load || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!out_valid_ff || rsp_ready))
      else $error("response register loaded while a result is pending");

   a_divide_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |=> (state_ff == ST_DIVIDE) || (state_ff == ST_PUBLISH))
      else $error("divider sequence left early");

   a_publish_follows: assert property (@(posedge clock) disable iff (reset)
      (req_take && !status.cmd_change) |=> (state_ff == ST_PUBLISH))
      else $error("request did not lead to a response");

endmodule

FILE: bench/testbench.sv
// Self-checking bench for buzzer_pattern_sequencer_unit: directed and random ticks and
// mode commands, with an in-bench prediction of every response and random idling.
// Depends on bps_pkg, the bps_req_if/bps_rsp_if channels and the unit under test.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import bps_pkg::*;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_CMD  = 1'b1;

   localparam int unsigned TONE_CLOCK_HZ = 1000000;
   localparam int unsigned CLAMP_LO_HZ   = 1000;
   localparam int unsigned CLAMP_HI_HZ   = 2000;
   localparam int unsigned BIND_LEN      = 500;
   localparam int unsigned ITEM_TARGET   = 1150;
   localparam int unsigned HOLD_AT       = 400;
   localparam int unsigned HOLD_LEN      = 300;
   localparam int unsigned DRAIN_CYCLES  = 40;
   localparam int unsigned IDLE_LIMIT    = 2000;

   typedef struct packed {
      logic                op;
      logic [FREQ_W-1:0]   tone_freq;
      logic [MODE_W-1:0]   mode_request;
   } tone_req_type;

   typedef struct packed {
      logic                buzzer_on;
      logic [PERIOD_W-1:0] tone_period;
      logic [HALF_W-1:0]   tone_half;
      logic [MODE_W-1:0]   current_mode;
   } tone_rsp_type;

   logic clock;
   logic reset;

   bps_req_if req_ch ();
   bps_rsp_if rsp_ch ();

   buzzer_pattern_sequencer_unit #(.BIND_CYCLE(BIND_LEN)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   tone_req_type pending_req[$];
   tone_rsp_type expected_rsp[$];

   mode_type            mode_q;
   logic [TICK_W-1:0]   count_q;
   logic                on_q;
   logic [PERIOD_W-1:0] period_q;
   logic [HALF_W-1:0]   half_q;

   int unsigned errors;
   int unsigned n_ticks;
   int unsigned n_cmds;
   int unsigned n_changes;
   int unsigned n_rsp;
   logic [9:0]  ticked_modes;

   tone_req_type cur_req;
   logic         req_fire;
   int unsigned  send_gap;
   int unsigned  send_calm;
   int unsigned  recv_stall;
   int unsigned  recv_calm;
   int unsigned  hold_left;
   logic         nxt_ready;
   tone_rsp_type got_rsp;
   int unsigned  idle_cycles;
   int unsigned  counted;
   mode_type     seq_mode;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int unsigned pick_gap(inout int unsigned calm);
      int unsigned r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm = $urandom_range(20, 80);
         return 0;
      end
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic in_band(int unsigned c, int unsigned lo, int unsigned hi);
      return (c >= lo) && (c < hi);
   endfunction

   function automatic void load_tone(int unsigned hz);
      period_q = PERIOD_W'(TONE_CLOCK_HZ / hz);
      half_q   = HALF_W'(TONE_CLOCK_HZ / (2 * hz));
      on_q     = 1'b1;
   endfunction

   function automatic void advance_one_shot(int unsigned lim);
      if (count_q < lim) count_q = count_q + 1'b1;
      else mode_q = MODE_STOP;
   endfunction

   function automatic void advance_wrap(int unsigned lim);
      if (count_q < lim) count_q = count_q + 1'b1;
      else count_q = '0;
   endfunction

   function automatic void step_bind();
      int unsigned c;
      if (count_q >= BIND_LEN) begin
         count_q = '0;
         return;
      end
      count_q = count_q + 1'b1;
      c = count_q;
      if (in_band(c, 40, 90) || in_band(c, 100, 150) || in_band(c, 160, 210) ||
          in_band(c, 280, 330) || in_band(c, 400, 500)) begin
         load_tone(512);
      end else if (in_band(c, 220, 255) || in_band(c, 340, 375)) begin
         load_tone(413);
      end else if (in_band(c, 255, 280) || in_band(c, 375, 400)) begin
         load_tone(610);
      end else begin
         on_q = 1'b0;
      end
   endfunction

   function automatic void step_pattern();
      case (mode_q)
         MODE_STOP: begin
            count_q = '0;
            on_q    = 1'b0;
         end
         MODE_CLICK: advance_one_shot(3);
         MODE_MID: advance_one_shot(20);
         MODE_EXIT: begin
            advance_one_shot(15);
            on_q = (count_q < 5) || (count_q > 10);
         end
         MODE_CALDONE: begin
            advance_one_shot(40);
            on_q = 1'b1;
         end
         MODE_BIND: step_bind();
         MODE_STATIC, MODE_RFLOST, MODE_THROTTLE: begin
            advance_wrap(100);
            on_q = count_q < 5;
            if (mode_q != MODE_STATIC) begin
               on_q = on_q || (count_q > 10 && count_q < 15) || (count_q > 20 && count_q < 25);
            end
            if (mode_q == MODE_THROTTLE) begin
               on_q = on_q || (count_q > 30 && count_q < 35);
            end
         end
         MODE_FAST: begin
            advance_wrap(10);
            on_q = count_q < 5;
         end
         default: ;
      endcase
   endfunction

   task automatic predict_tone(input tone_req_type it);
      tone_rsp_type r;
      int unsigned  hz;
      if (it.op == OP_CMD) begin
         n_cmds++;
         if (it.mode_request <= MODE_FAST && it.mode_request != mode_q) begin
            hz = it.tone_freq;
            if (hz > CLAMP_HI_HZ) hz = CLAMP_HI_HZ;
            else if (hz < CLAMP_LO_HZ) hz = CLAMP_LO_HZ;
            load_tone(hz);
            mode_q  = mode_type'(it.mode_request);
            count_q = '0;
            n_changes++;
         end
      end else begin
         n_ticks++;
         ticked_modes[mode_q] = 1'b1;
         step_pattern();
      end
      r.buzzer_on    = on_q;
      r.tone_period  = period_q;
      r.tone_half    = half_q;
      r.current_mode = mode_q;
      expected_rsp.push_back(r);
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch in %s at response %0d: got %0d, expected %0d", what, n_rsp, got, want);
      errors++;
   endtask

   task automatic check_response(input tone_rsp_type got);
      tone_rsp_type want;
      if (expected_rsp.size() == 0) begin
         report_mismatch("response with nothing expected", got.current_mode, -1);
         return;
      end
      want = expected_rsp.pop_front();
      if (got.buzzer_on !== want.buzzer_on)
         report_mismatch("buzzer_on", got.buzzer_on, want.buzzer_on);
      if (got.tone_period !== want.tone_period)
         report_mismatch("tone_period", got.tone_period, want.tone_period);
      if (got.tone_half !== want.tone_half)
         report_mismatch("tone_half", got.tone_half, want.tone_half);
      if (got.current_mode !== want.current_mode)
         report_mismatch("current_mode", got.current_mode, want.current_mode);
   endtask

   task automatic push_item(input logic op, input int unsigned freq, input int unsigned mode);
      tone_req_type it;
      it.op           = op;
      it.tone_freq    = FREQ_W'(freq);
      it.mode_request = MODE_W'(mode);
      pending_req.push_back(it);
      if (op == OP_TICK || mode <= MODE_FAST) counted++;
   endtask

   task automatic push_ticks(input int unsigned n);
      repeat (n) push_item(OP_TICK, $urandom_range(0, 65535), $urandom_range(0, 15));
   endtask

   function automatic int unsigned pattern_ticks(mode_type m);
      case (m)
         MODE_STOP:    return $urandom_range(1, 4);
         MODE_CLICK:   return $urandom_range(1, 7);
         MODE_MID:     return $urandom_range(1, 24);
         MODE_EXIT:    return $urandom_range(1, 19);
         MODE_CALDONE: return $urandom_range(1, 44);
         MODE_BIND:    return ($urandom_range(0, 3) == 0) ? BIND_LEN + 5 : $urandom_range(1, 120);
         MODE_FAST:    return $urandom_range(1, 30);
         default:      return $urandom_range(1, 205);
      endcase
   endfunction

   function automatic int unsigned random_freq();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 65535);
         1: return $urandom_range(900, 2100);
         2: return ($urandom_range(0, 1) == 0) ? CLAMP_LO_HZ : CLAMP_HI_HZ;
         default: return $urandom_range(CLAMP_LO_HZ, CLAMP_HI_HZ);
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         req_fire = req_ch.valid && req_ch.ready;
         if (req_fire) begin
            predict_tone(cur_req);
            send_gap = pick_gap(send_calm);
         end
         if (!req_ch.valid || req_fire) begin
            if (send_gap > 0) begin
               send_gap--;
               req_ch.valid <= 1'b0;
            end else if (pending_req.size() > 0) begin
               cur_req = pending_req.pop_front();
               req_ch.valid        <= 1'b1;
               req_ch.op           <= cur_req.op;
               req_ch.tone_freq    <= cur_req.tone_freq;
               req_ch.mode_request <= cur_req.mode_request;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got_rsp.buzzer_on    = rsp_ch.buzzer_on;
            got_rsp.tone_period  = rsp_ch.tone_period;
            got_rsp.tone_half    = rsp_ch.tone_half;
            got_rsp.current_mode = rsp_ch.current_mode;
            check_response(got_rsp);
            n_rsp++;
            if (n_rsp == HOLD_AT) hold_left = HOLD_LEN;
            else recv_stall = pick_gap(recv_calm);
         end
         if (hold_left > 0) begin
            hold_left--;
            nxt_ready = 1'b0;
         end else if (recv_stall > 0) begin
            recv_stall--;
            nxt_ready = 1'b0;
         end else begin
            nxt_ready = 1'b1;
         end
         rsp_ch.ready <= nxt_ready;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.op           = OP_TICK;
      req_ch.tone_freq    = '0;
      req_ch.mode_request = '0;
      rsp_ch.ready        = 1'b0;
      mode_q       = MODE_STOP;
      count_q      = '0;
      on_q         = 1'b0;
      period_q     = PERIOD_W'(1000);
      half_q       = HALF_W'(500);
      errors       = 0;
      n_ticks      = 0;
      n_cmds       = 0;
      n_changes    = 0;
      n_rsp        = 0;
      ticked_modes = '0;
      send_gap     = 0;
      send_calm    = 0;
      recv_stall   = 0;
      recv_calm    = 0;
      hold_left    = 0;
      idle_cycles  = 0;
      counted      = 0;

      // Directed part: tone clamps, repeated and unknown modes, one-shot ending,
      // commanded stop and a first visit to every pattern.
      push_item(OP_TICK, 0, MODE_STOP);
      push_item(OP_CMD, 0, MODE_CLICK);
      push_ticks(5);
      push_item(OP_CMD, 65535, MODE_MID);
      push_item(OP_CMD, 1500, MODE_MID);
      push_item(OP_CMD, 2001, 15);
      push_item(OP_CMD, 1700, 10);
      push_ticks(1);
      push_item(OP_CMD, 999, MODE_STOP);
      push_ticks(1);
      push_item(OP_CMD, 1000, MODE_EXIT);
      push_item(OP_CMD, 2000, MODE_CALDONE);
      push_ticks(1);
      push_item(OP_CMD, 1234, MODE_BIND);
      push_ticks(1);
      push_item(OP_CMD, 1001, MODE_STATIC);
      push_ticks(1);
      push_item(OP_CMD, 1999, MODE_RFLOST);
      push_ticks(1);
      push_item(OP_CMD, 32768, MODE_THROTTLE);
      push_ticks(1);
      push_item(OP_CMD, 1, MODE_FAST);
      push_ticks(1);

      counted = 0;
      while (counted < ITEM_TARGET) begin
         case ($urandom_range(0, 9))
            0: push_item(1'($urandom_range(0, 1)), $urandom_range(0, 65535),
                         $urandom_range(0, 15));
            1: begin
               push_item(OP_CMD, random_freq(), $urandom_range(0, 15));
               push_ticks($urandom_range(0, 3));
            end
            default: begin
               seq_mode = mode_type'($urandom_range(0, 9));
               push_item(OP_CMD, random_freq(), seq_mode);
               if ($urandom_range(0, 7) == 0) push_item(OP_CMD, random_freq(), seq_mode);
               push_ticks(pattern_ticks(seq_mode));
            end
         endcase
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      do begin
         @(posedge clock);
         #1;
      end while (pending_req.size() != 0 || req_ch.valid || expected_rsp.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d ticks and %0d mode commands (%0d mode changes), %0d responses",
               n_ticks, n_cmds, n_changes, n_rsp);
      $display("patterns ticked (mode 9..0): %b, receiver held off %0d cycles once",
               ticked_modes, HOLD_LEN);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
